// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the interval membership table.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion violated");

// Check that a condition never holds while out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

// ===== rtl/imt_pkg.sv =====
// Package of the interval membership table: sizes, codes, state and struct types.
// No dependencies; used by the interfaces, the controller and the top level.
package imt_pkg;

    localparam int MAX_RANGES = 256;
    localparam int ADDR_W     = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int COUNT_W    = $clog2(MAX_RANGES + 1);
    localparam int VALUE_W    = 64;
    localparam int HITS_W     = 32;
    localparam int ENTRY_W    = 2 * VALUE_W;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              hit;
        logic [HITS_W-1:0] hit_count;
        logic              table_full;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } t_ram_req;

endpackage

// ===== rtl/imt_if.sv =====
// Valid/ready channel interfaces of the interval membership table.
// Depends on imt_pkg for field widths.
interface imt_in_if;
    import imt_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic [VALUE_W-1:0] range_start;
    logic [VALUE_W-1:0] range_end;
    logic [VALUE_W-1:0] query_value;

    modport source (output valid, func, range_start, range_end, query_value, input ready);
    modport sink   (input valid, func, range_start, range_end, query_value, output ready);
endinterface

interface imt_out_if;
    import imt_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [HITS_W-1:0] hit_count;
    logic              table_full;

    modport source (output valid, hit, hit_count, table_full, input ready);
    modport sink   (input valid, hit, hit_count, table_full, output ready);
endinterface

// ===== rtl/imt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module imt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/imt_ctrl.sv =====
// Sequencer of the interval membership table: insert, table scan, hit count.
// Depends on imt_pkg and imt_in_if; drives the range RAM through a request struct.
module imt_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    imt_in_if.sink                  i_in,
    input  logic [imt_pkg::ENTRY_W-1:0] i_ram_rdata,
    output imt_pkg::t_ram_req       o_ram_req,
    output logic                    o_res_valid,
    output imt_pkg::t_result        o_res,
    input  logic                    i_res_take
);
    import imt_pkg::*;

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [HITS_W-1:0]    r_hits, n_hits;
    logic [ADDR_W-1:0]    r_idx, n_idx;
    logic [VALUE_W-1:0]   r_value, n_value;
    t_result              r_res, n_res;
    logic                 accept;
    logic [VALUE_W-1:0]   ent_start;
    logic [VALUE_W-1:0]   ent_end;
    logic                 match;
    logic                 last;
    logic [HITS_W-1:0]    hits_inc;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // Split the entry read back and test the held value against it
    assign ent_start = i_ram_rdata[ENTRY_W-1:VALUE_W];
    assign ent_end   = i_ram_rdata[VALUE_W-1:0];
    assign match     = (ent_start <= r_value) && (r_value <= ent_end);
    assign last      = (COUNT_W'(r_idx) == (r_count - COUNT_W'(1)));
    assign hits_inc  = (r_hits == '1) ? r_hits : (r_hits + HITS_W'(1));

    // Hold state, count, hit total and the pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_hits  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hits  <= n_hits;
        end
        r_idx   <= n_idx;
        r_value <= n_value;
        r_res   <= n_res;
    end

    // Next state, RAM requests and result
    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_hits          = r_hits;
        n_idx           = r_idx;
        n_value         = r_value;
        n_res           = r_res;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_count[ADDR_W-1:0];
        o_ram_req.wdata = {i_in.range_start, i_in.range_end};
        o_ram_req.raddr = r_idx;
        o_res_valid     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res.hit        = 1'b0;
                    n_res.hit_count  = r_hits;
                    n_res.table_full = 1'b0;
                    n_value          = i_in.query_value;
                    n_state          = ST_DONE;
                    if (i_in.func == FUNC_INSERT) begin
                        // Append the range, or flag the drop on a full table
                        if (r_count >= COUNT_W'(MAX_RANGES)) begin
                            n_res.table_full = 1'b1;
                        end else begin
                            o_ram_req.we = 1'b1;
                            n_count      = r_count + COUNT_W'(1);
                        end
                    end else if (r_count != '0) begin
                        // Start the scan at the first entry
                        o_ram_req.raddr = '0;
                        n_idx           = '0;
                        n_state         = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (match) begin
                    n_hits          = hits_inc;
                    n_res.hit       = 1'b1;
                    n_res.hit_count = hits_inc;
                    n_state         = ST_DONE;
                end else if (last) begin
                    n_state = ST_DONE;
                end else begin
                    o_ram_req.raddr = r_idx + ADDR_W'(1);
                    n_idx           = r_idx + ADDR_W'(1);
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res = r_res;
endmodule

// ===== rtl/interval_membership_table.sv =====
// Top level of the interval membership table: range RAM, sequencer, output register.
// Depends on imt_pkg, imt_in_if/imt_out_if, imt_ram, imt_ctrl and assert_macros.svh.
//
// Usage:
//   i_in carries one word per operation: func selects insert (range_start,
//   range_end) or query (query_value). o_out returns exactly one word per
//   input word: hit, the saturating hit_count after the operation, and
//   table_full for an insert dropped on a full table.
//   An insert passes from idle to the done state, where its result waits
//   until the output register takes it.
//   A query reads one stored range per cycle from the range RAM, whose single
//   read port sets the rate, and stops at the first stored range that
//   matches. A query on an empty table skips the scan and misses. One word
//   is in work at a time; i_in.ready is high while the sequencer is idle,
//   also while a result waits in the output register.
//   Reset empties the table and clears the hit count; no clearing pass is
//   needed. When the receiver stalls, the output register holds its word and
//   the next finished result waits in the sequencer until the register frees.
`include "assert_macros.svh"

module interval_membership_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    imt_in_if.sink    i_in,
    imt_out_if.source o_out
);
    import imt_pkg::*;

    t_ram_req           ram_req;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               res_valid;
    t_result            res;
    logic               res_take;
    logic               r_out_valid;
    t_result            r_out;

    // Start and end of each range, packed into one entry
    imt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RANGES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    imt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_ram_rdata (ram_rdata),
        .o_ram_req   (ram_req),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // Load the output register when it is empty or being drained
    assign res_take = res_valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.hit        = r_out.hit;
    assign o_out.hit_count  = r_out.hit_count;
    assign o_out.table_full = r_out.table_full;

    // One word in work at a time: an accepted word closes the input
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> !i_in.ready)
    // A finished result waits until the output register takes it
    `ASSERT_CLK(a_res_held, i_clk, i_rst_n, (res_valid && !res_take) |=> res_valid)
    // A hit always leaves a nonzero hit count
    `ASSERT_NEVER(a_hit_count, i_clk, i_rst_n, o_out.valid && o_out.hit && (o_out.hit_count == '0))
    // A word never reports a hit and a dropped insert together
    `ASSERT_NEVER(a_hit_full, i_clk, i_rst_n, o_out.valid && o_out.hit && o_out.table_full)
endmodule

// ===== sim/interval_membership_table_tb.sv =====
`timescale 1ns / 1ps
// Testbench of the interval membership table: directed and random insert/query words,
// checked against an in-bench table predictor. Depends on imt_pkg, imt_if and the RTL.
module interval_membership_table_tb;
    import imt_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam logic [VALUE_W-1:0] TOP_VALUE = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    imt_in_if  in_ch ();
    imt_out_if out_ch ();

    interval_membership_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predicted table contents and hit counter
    logic [VALUE_W-1:0] range_lo [MAX_RANGES];
    logic [VALUE_W-1:0] range_hi [MAX_RANGES];
    int unsigned        n_ranges = 0;
    logic [HITS_W-1:0]  hits_seen = '0;

    t_result     awaited_answers [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned tx_idle_pct = 8;
    int unsigned rx_idle_pct = 88;
    int unsigned rx_hold_left = 0;

    // Generate a 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [VALUE_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Apply one word to the predicted table and return the answer it yields
    function automatic t_result predict_membership(input logic fn,
                                                   input logic [VALUE_W-1:0] lo, hi, probe);
        t_result r;
        r = '0;
        if (fn == FUNC_INSERT) begin
            if (n_ranges >= MAX_RANGES) begin
                r.table_full = 1'b1;
            end else begin
                range_lo[n_ranges] = lo;
                range_hi[n_ranges] = hi;
                n_ranges++;
            end
        end else begin
            for (int k = 0; k < n_ranges; k++) begin
                if (range_lo[k] <= probe && probe <= range_hi[k]) r.hit = 1'b1;
            end
            // saturate rather than wrap
            if (r.hit && hits_seen != '1) hits_seen++;
        end
        r.hit_count = hits_seen;
        return r;
    endfunction

    // Draw a range: inverted, single point, wide, near either end, or narrow
    function automatic void pick_range(output logic [VALUE_W-1:0] lo, hi);
        logic [VALUE_W-1:0] a, b;
        a = rand64();
        b = rand64();
        case ($urandom_range(7))
            0: begin
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            1: begin
                lo = a;
                hi = a;
            end
            2: begin
                lo = a >> $urandom_range(63);
                hi = lo + (b >> $urandom_range(63));
                if (hi < lo) hi = TOP_VALUE;
            end
            3: begin
                lo = $urandom_range(255);
                hi = lo + $urandom_range(4095);
            end
            4: begin
                hi = TOP_VALUE;
                lo = hi - $urandom_range(4095);
            end
            default: begin
                lo = a;
                hi = a + $urandom_range(65535);
                if (hi < lo) hi = TOP_VALUE;
            end
        endcase
    endfunction

    // Aim about half the queries at the edges of stored ranges
    function automatic logic [VALUE_W-1:0] pick_probe();
        int unsigned k;
        if (n_ranges == 0 || $urandom_range(99) < 45) return rand64();
        k = $urandom_range(n_ranges - 1);
        case ($urandom_range(4))
            0: return range_lo[k] - 1;
            1: return range_lo[k];
            2: return range_hi[k];
            3: return range_hi[k] + 1;
            default: return range_lo[k] + ((range_hi[k] - range_lo[k]) >> 1);
        endcase
    endfunction

    // Offer one word, hold it until accepted, then record its predicted answer
    task automatic send_word(input logic fn, input logic [VALUE_W-1:0] lo, hi, probe);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= fn;
        in_ch.range_start <= lo;
        in_ch.range_end   <= hi;
        in_ch.query_value <= probe;
        do @(posedge i_clk); while (!in_ch.ready);
        awaited_answers.push_back(predict_membership(fn, lo, hi, probe));
    endtask

    task automatic send_insert(input logic [VALUE_W-1:0] lo, hi);
        send_word(FUNC_INSERT, lo, hi, rand64());
    endtask

    task automatic send_query(input logic [VALUE_W-1:0] probe);
        send_word(FUNC_QUERY, rand64(), rand64(), probe);
    endtask

    // Queries on an empty table must miss
    task automatic test_empty_table();
        send_query('0);
        send_query(TOP_VALUE);
    endtask

    // Field extremes, single points, an inverted range and the bounds of a normal one
    task automatic test_range_edges();
        send_insert('0, '0);
        send_insert(TOP_VALUE, TOP_VALUE);
        send_insert(64'd100, 64'd50);
        send_insert(64'd1000, 64'd2000);
        send_query('0);
        send_query(64'd1);
        send_query(TOP_VALUE);
        send_query(TOP_VALUE - 1);
        send_query(64'd75);
        send_query(64'd50);
        send_query(64'd100);
        send_query(64'd999);
        send_query(64'd1000);
        send_query(64'd1500);
        send_query(64'd2000);
        send_query(64'd2001);
    endtask

    // Hold the receiver off long enough that the block backs up into its input
    task automatic test_stalled_receiver();
        tx_idle_pct  = 0;
        rx_hold_left = 600;
        repeat (10) send_query(pick_probe());
        tx_idle_pct = 8;
    endtask

    // Random inserts and queries under the given idle rates
    task automatic test_mixed_traffic(input int unsigned tx_pct, rx_pct, n_words);
        logic [VALUE_W-1:0] lo, hi;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n_words) begin
            if ($urandom_range(99) < 35) begin
                pick_range(lo, hi);
                send_insert(lo, hi);
            end else begin
                send_query(pick_probe());
            end
        end
    endtask

    // Fill the table, then check that further inserts are dropped
    task automatic test_full_table();
        logic [VALUE_W-1:0] lo, hi;
        while (n_ranges < MAX_RANGES) begin
            pick_range(lo, hi);
            send_insert(lo, hi);
        end
        send_insert('0, TOP_VALUE);
        send_insert(TOP_VALUE, '0);
        repeat (4) begin
            pick_range(lo, hi);
            send_insert(lo, hi);
        end
        send_query(rand64());
        send_query(pick_probe());
    endtask

    // Drive the receiver ready: random idling, or a counted hold-off when requested
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Compare each answer word with the oldest prediction
    always @(posedge i_clk) begin : check_answers
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (awaited_answers.size() == 0) begin
                $error("answer word arrived with no prediction pending");
                mismatch_count++;
            end else begin
                want = awaited_answers.pop_front();
                if (out_ch.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, out_ch.hit);
                    mismatch_count++;
                end
                if (out_ch.hit_count !== want.hit_count) begin
                    $error("hit_count: expected %0d, got %0d", want.hit_count, out_ch.hit_count);
                    mismatch_count++;
                end
                if (out_ch.table_full !== want.table_full) begin
                    $error("table_full: expected %0d, got %0d",
                           want.table_full, out_ch.table_full);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when no word moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.func        = FUNC_INSERT;
        in_ch.range_start = '0;
        in_ch.range_end   = '0;
        in_ch.query_value = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_range_edges();
        test_stalled_receiver();
        test_mixed_traffic(8, 88, 340);
        test_mixed_traffic(88, 8, 340);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_full_table();
        test_mixed_traffic(0, 0, 300);

        // Drop valid and drain the remaining answers
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
